@@ hdl/stwe_pkg.sv @@
// Shared types and constants for the subscription table with expiry.
// Used by every module of the block but stwe_slot_ram; no dependencies of its own.
package stwe_pkg;

    // Table geometry
    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int TIME_W = 32;
    localparam int LEN_W  = 16;
    localparam int SLOT_FIELD_W = 4;

    // Reset value of the service length register, in seconds
    localparam logic [LEN_W-1:0] SERVICE_LEN_RESET = LEN_W'(30);

    // Request kinds
    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_SWEEP    = 1'b1;

    // Result codes
    typedef enum logic [2:0] {
        OC_ACCEPTED = 3'd0,
        OC_REFUSED  = 3'd1,
        OC_NOTICE   = 3'd2,
        OC_ENDED    = 3'd3,
        OC_DONE     = 3'd4
    } outcome_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    // One stored subscriber
    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] created;
    } slot_entry_t;

    // One result word
    typedef struct packed {
        outcome_t                  outcome;
        logic [SLOT_FIELD_W-1:0]   slot;
        logic [IP_W-1:0]           dest_ip;
        logic [PORT_W-1:0]         dest_port;
        logic [TIME_W-1:0]         time_stamp;
        logic                      last;
    } result_t;

endpackage

@@ hdl/stwe_slot_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the subscriber entries; no package dependencies.
module stwe_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 80
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/stwe_age_cmp.sv @@
// Expiry test: unsigned 32-bit age against the service length.
// Depends on stwe_pkg for field widths.
module stwe_age_cmp (
    input  logic [stwe_pkg::TIME_W-1:0] now,
    input  logic [stwe_pkg::TIME_W-1:0] created,
    input  logic [stwe_pkg::LEN_W-1:0]  service_length,
    output logic                        expired
);
    import stwe_pkg::*;

    logic [TIME_W-1:0] age;

    // Modulo-2^32 difference handles time wrap
    always_comb
    begin
        age     = now - created;
        expired = (age > TIME_W'(service_length));
    end

endmodule

@@ hdl/subscription_table_with_expiry.sv @@
// Top level of the subscription table with expiry.
// Depends on stwe_pkg, stwe_slot_ram and stwe_age_cmp.
//
// A register word (kind 0) answers accepted or refused in the next cycle;
// busy stays low. A sweep word (kind 1) raises busy while the sequencer
// walks the slots one per cycle through the slot RAM's registered read
// port and the single age comparator, then drains the read stage; the
// done word is strobed in the same cycle that busy drops. Results appear
// at most one per cycle on the strobe (empty slots leave gaps), in slot
// order, with last set only on the final word of each request. The
// receiver cannot hold results off, so consume every strobed word. Write
// service_length only while busy is low and no result is pending.
module subscription_table_with_expiry (
    input  logic                         clk,
    input  logic                         rst_n,
    // Request
    input  logic                         start,
    output logic                         busy,
    input  logic                         kind,
    input  logic [stwe_pkg::IP_W-1:0]    client_ip,
    input  logic [stwe_pkg::PORT_W-1:0]  client_port,
    input  logic [stwe_pkg::TIME_W-1:0]  now,
    // Configuration
    input  logic                         service_length_we,
    input  logic [stwe_pkg::LEN_W-1:0]   service_length,
    // Results
    output logic                         strobe,
    output logic [2:0]                   outcome,
    output logic [stwe_pkg::SLOT_FIELD_W-1:0] slot,
    output logic [stwe_pkg::IP_W-1:0]    dest_ip,
    output logic [stwe_pkg::PORT_W-1:0]  dest_port,
    output logic [stwe_pkg::TIME_W-1:0]  time_stamp,
    output logic                         last
);
    import stwe_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [LEN_W-1:0]  len_reg;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic              p_vld_reg, p_vld_next;
    logic [SLOT_W-1:0] p_idx_reg, p_idx_next;
    logic              strobe_reg, strobe_next;
    result_t           res_reg, res_next;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_raddr;
    slot_entry_t       ram_wdata;
    slot_entry_t       ram_rdata;
    logic              expired;

    logic              found;
    logic [SLOT_W-1:0] free_idx;

    // Slot storage
    stwe_slot_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W),
        .DATA_W ($bits(slot_entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared age comparator
    stwe_age_cmp u_age (
        .now            (now_reg),
        .created        (ram_rdata.created),
        .service_length (len_reg),
        .expired        (expired)
    );

    // Lowest free slot
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                found    = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            valid_reg  <= '0;
            p_vld_reg  <= 1'b0;
            strobe_reg <= 1'b0;
            len_reg    <= SERVICE_LEN_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            valid_reg  <= valid_next;
            p_vld_reg  <= p_vld_next;
            strobe_reg <= strobe_next;
            if (service_length_we)
            begin
                len_reg <= service_length;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        p_idx_reg <= p_idx_next;
        res_reg   <= res_next;
    end

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        now_next    = now_reg;
        valid_next  = valid_reg;
        p_vld_next  = 1'b0;
        p_idx_next  = p_idx_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        ram_we      = 1'b0;
        ram_raddr   = idx_reg;
        ram_wdata.ip      = client_ip;
        ram_wdata.port    = client_port;
        ram_wdata.created = now;

        // Read stage: evaluate the slot fetched last cycle
        if (p_vld_reg)
        begin
            strobe_next        = 1'b1;
            res_next.slot      = SLOT_FIELD_W'(p_idx_reg);
            res_next.dest_ip   = ram_rdata.ip;
            res_next.dest_port = ram_rdata.port;
            res_next.last      = 1'b0;
            if (expired)
            begin
                res_next.outcome       = OC_ENDED;
                res_next.time_stamp    = '0;
                valid_next[p_idx_reg]  = 1'b0;
            end
            else
            begin
                res_next.outcome    = OC_NOTICE;
                res_next.time_stamp = now_reg;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_SWEEP)
                    begin
                        now_next   = now;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        strobe_next         = 1'b1;
                        res_next.dest_ip    = client_ip;
                        res_next.dest_port  = client_port;
                        res_next.time_stamp = '0;
                        res_next.last       = 1'b1;
                        if (found)
                        begin
                            ram_we               = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            res_next.outcome     = OC_ACCEPTED;
                            res_next.slot        = SLOT_FIELD_W'(free_idx);
                        end
                        else
                        begin
                            res_next.outcome = OC_REFUSED;
                            res_next.slot    = '0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue one slot read per cycle; empty slots are skipped
                p_vld_next = valid_reg[idx_reg];
                p_idx_next = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                strobe_next         = 1'b1;
                res_next.outcome    = OC_DONE;
                res_next.slot       = '0;
                res_next.dest_ip    = '0;
                res_next.dest_port  = '0;
                res_next.time_stamp = '0;
                res_next.last       = 1'b1;
                state_next          = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Port drive
    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign outcome    = res_reg.outcome;
    assign slot       = res_reg.slot;
    assign dest_ip    = res_reg.dest_ip;
    assign dest_port  = res_reg.dest_port;
    assign time_stamp = res_reg.time_stamp;
    assign last       = res_reg.last;

    // Table writes happen only between sweeps
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("slot write during sweep");

    // Read stage is live only while the sweep walks or drains
    a_pipe_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        p_vld_reg |-> (state_reg == ST_SCAN || state_reg == ST_FLUSH))
        else $error("slot evaluation outside sweep");

    // A sweep closes with the done word
    a_sweep_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> (strobe_reg && res_reg.last
                                    && res_reg.outcome == OC_DONE))
        else $error("sweep did not end with done word");

    // A register request answers with a single final word
    a_register_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_REGISTER) |=> (strobe_reg && res_reg.last))
        else $error("register request not answered");

    // Only the done word or a register answer carries last
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && res_reg.last) |->
            (res_reg.outcome == OC_DONE || res_reg.outcome == OC_ACCEPTED
             || res_reg.outcome == OC_REFUSED))
        else $error("last set on a slot word");

endmodule

@@ bench/subscription_table_with_expiry_test.sv @@
// Self-checking bench for subscription_table_with_expiry: directed and random
// register/sweep words against an in-bench table predictor. Depends on stwe_pkg.
module subscription_table_with_expiry_test;
    import stwe_pkg::*;

    localparam int SETTLE  = 4;       // quiet cycles before a drain or a length write
    localparam int TAIL    = 30;      // cycles watched after the last result
    localparam int LIMIT   = 200000;  // hard stop, in clock cycles
    localparam int PHASES  = 6;
    localparam int PHASE_N = 64;      // random words per phase

    typedef enum logic [1:0] {
        ACT_WORD,       // drive one request word
        ACT_WRITE_LEN,  // write service_length once quiet
        ACT_DRAIN       // hold off until every result is in
    } req_op_t;

    typedef struct {
        req_op_t            op;
        logic               kind;
        logic [IP_W-1:0]    ip;
        logic [PORT_W-1:0]  port;
        logic [TIME_W-1:0]  stamp;
        logic [LEN_W-1:0]   len;
        int                 gap_pct;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                start = 1'b0;
    logic                busy;
    logic                kind = KIND_REGISTER;
    logic [IP_W-1:0]     client_ip = '0;
    logic [PORT_W-1:0]   client_port = '0;
    logic [TIME_W-1:0]   now = '0;
    logic                cfg_len_we = 1'b0;
    logic [LEN_W-1:0]    cfg_len = '0;

    logic                strobe;
    logic [2:0]          outcome;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [IP_W-1:0]     dest_ip;
    logic [PORT_W-1:0]   dest_port;
    logic [TIME_W-1:0]   time_stamp;
    logic                last;

    request_t requests[$];
    result_t  expected_results[$];
    int       errors = 0;
    int       idle_run = 0;
    int       cycle_count = 0;

    // Predicted table contents
    logic               tbl_valid [SLOTS];
    logic [IP_W-1:0]    tbl_ip [SLOTS];
    logic [PORT_W-1:0]  tbl_port [SLOTS];
    logic [TIME_W-1:0]  tbl_created [SLOTS];
    logic [LEN_W-1:0]   svc_len = SERVICE_LEN_RESET;

    subscription_table_with_expiry DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .kind              (kind),
        .client_ip         (client_ip),
        .client_port       (client_port),
        .now               (now),
        .service_length_we (cfg_len_we),
        .service_length    (cfg_len),
        .strobe            (strobe),
        .outcome           (outcome),
        .slot              (slot),
        .dest_ip           (dest_ip),
        .dest_port         (dest_port),
        .time_stamp        (time_stamp),
        .last              (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
        end
    end

    // Apply one accepted word to the predicted table, queue the results it causes
    task automatic apply_to_table(input logic k, input logic [IP_W-1:0] ip,
                                  input logic [PORT_W-1:0] port, input logic [TIME_W-1:0] t);
        result_t r;
        logic [TIME_W-1:0] age;
        bit placed;
        int i;
        placed = 0;
        if (k == KIND_REGISTER)
        begin
            // lowest free slot wins
            for (i = 0; i < SLOTS; i++)
            begin
                if (!placed && !tbl_valid[i])
                begin
                    tbl_valid[i] = 1'b1;
                    tbl_ip[i] = ip;
                    tbl_port[i] = port;
                    tbl_created[i] = t;
                    r.outcome = OC_ACCEPTED;
                    r.slot = SLOT_FIELD_W'(i);
                    placed = 1;
                end
            end
            if (!placed)
            begin
                r.outcome = OC_REFUSED;
                r.slot = '0;
            end
            r.dest_ip = ip;
            r.dest_port = port;
            r.time_stamp = '0;
            r.last = 1'b1;
            expected_results.push_back(r);
        end
        else
        begin
            // sweep: wrap-safe age against the service length
            for (i = 0; i < SLOTS; i++)
            begin
                if (tbl_valid[i])
                begin
                    age = t - tbl_created[i];
                    r.slot = SLOT_FIELD_W'(i);
                    r.dest_ip = tbl_ip[i];
                    r.dest_port = tbl_port[i];
                    r.last = 1'b0;
                    if (age > TIME_W'(svc_len))
                    begin
                        tbl_valid[i] = 1'b0;
                        r.outcome = OC_ENDED;
                        r.time_stamp = '0;
                    end
                    else
                    begin
                        r.outcome = OC_NOTICE;
                        r.time_stamp = t;
                    end
                    expected_results.push_back(r);
                end
            end
            r.outcome = OC_DONE;
            r.slot = '0;
            r.dest_ip = '0;
            r.dest_port = '0;
            r.time_stamp = '0;
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic queue_word(input logic k, input logic [IP_W-1:0] ip,
                              input logic [PORT_W-1:0] port, input logic [TIME_W-1:0] t,
                              input int gap);
        request_t q;
        q.op = ACT_WORD;
        q.kind = k;
        q.ip = ip;
        q.port = port;
        q.stamp = t;
        q.len = '0;
        q.gap_pct = gap;
        requests.push_back(q);
    endtask

    task automatic queue_ctrl(input req_op_t op, input logic [LEN_W-1:0] len);
        request_t q;
        q.op = op;
        q.kind = KIND_REGISTER;
        q.ip = '0;
        q.port = '0;
        q.stamp = '0;
        q.len = len;
        q.gap_pct = 0;
        requests.push_back(q);
    endtask

    // Driver: one request word at a time, random gaps, noise on idle inputs
    always @(posedge clk)
    begin : driver
        logic              nxt_start;
        logic              nxt_we;
        logic              nxt_kind;
        logic [IP_W-1:0]   nxt_ip;
        logic [PORT_W-1:0] nxt_port;
        logic [TIME_W-1:0] nxt_now;
        logic [LEN_W-1:0]  nxt_len;
        nxt_start = start;
        nxt_we = 1'b0;
        nxt_kind = kind;
        nxt_ip = client_ip;
        nxt_port = client_port;
        nxt_now = now;
        nxt_len = cfg_len;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                requests.delete(0);
                nxt_start = 1'b0;
            end
            if (!start && !busy && !strobe)
                idle_run <= idle_run + 1;
            else
                idle_run <= 0;
            if (!nxt_start && requests.size() != 0)
            begin
                if (requests[0].op == ACT_WORD)
                begin
                    if ($urandom_range(0, 99) >= requests[0].gap_pct)
                    begin
                        nxt_start = 1'b1;
                        nxt_kind = requests[0].kind;
                        nxt_ip = requests[0].ip;
                        nxt_port = requests[0].port;
                        nxt_now = requests[0].stamp;
                    end
                end
                else if (!start && !busy && !strobe && idle_run >= SETTLE
                         && expected_results.size() == 0)
                begin
                    if (requests[0].op == ACT_WRITE_LEN)
                    begin
                        nxt_we = 1'b1;
                        nxt_len = requests[0].len;
                    end
                    requests.delete(0);
                end
            end
            // idle inputs carry garbage the block must ignore
            if (!nxt_start)
            begin
                nxt_kind = 1'($urandom_range(0, 1));
                nxt_ip = $urandom();
                nxt_port = PORT_W'($urandom());
                nxt_now = $urandom();
            end
            if (!nxt_we)
                nxt_len = LEN_W'($urandom());
            start <= nxt_start;
            cfg_len_we <= nxt_we;
            kind <= nxt_kind;
            client_ip <= nxt_ip;
            client_port <= nxt_port;
            now <= nxt_now;
            cfg_len <= nxt_len;
        end
    end

    // Monitor: check strobed words, then track config and accepted requests
    always @(posedge clk)
    begin : monitor
        result_t exp_w;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual outcome %0d slot %0d",
                             $time, outcome, slot);
                    errors++;
                end
                else
                begin
                    exp_w = expected_results.pop_front();
                    check_field("outcome", 32'(exp_w.outcome), 32'(outcome));
                    check_field("slot", 32'(exp_w.slot), 32'(slot));
                    check_field("dest_ip", exp_w.dest_ip, dest_ip);
                    check_field("dest_port", 32'(exp_w.dest_port), 32'(dest_port));
                    check_field("time_stamp", exp_w.time_stamp, time_stamp);
                    check_field("last", 32'(exp_w.last), 32'(last));
                end
            end
            if (cfg_len_we)
                svc_len = cfg_len;
            if (start && !busy)
                apply_to_table(kind, client_ip, client_port, now);
        end
    end

    // Hard stop
    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        logic [TIME_W-1:0] cursor;
        logic [LEN_W-1:0]  len;
        int item_no;
        int roll;
        int gap;

        // empty sweep, both field extremes, boundary and wrapped ages
        queue_word(KIND_SWEEP, $urandom(), PORT_W'($urandom()), 32'd0, 35);
        queue_word(KIND_REGISTER, 32'h0000_0000, 16'h0000, 32'h0000_0000, 35);
        queue_word(KIND_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 35);
        queue_word(KIND_SWEEP, '0, '0, 32'd30, 35);
        queue_word(KIND_SWEEP, '0, '0, 32'd31, 35);
        // fill every slot, then one refused
        for (int i = 0; i <= SLOTS; i++)
            queue_word(KIND_REGISTER, $urandom(), PORT_W'($urandom()), 32'd100 + i, 35);
        // all live, then far-off time ends them all
        queue_word(KIND_SWEEP, '0, '0, 32'd130, 35);
        queue_word(KIND_SWEEP, '0, '0, 32'hFFFF_FFFF, 35);

        item_no = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: len = 16'd0;
                1: len = 16'hFFFF;
                2: len = 16'd1;
                3: len = LEN_W'($urandom_range(2, 60));
                4: len = LEN_W'($urandom());
                default: len = SERVICE_LEN_RESET;
            endcase
            queue_ctrl(ACT_DRAIN, '0);
            queue_ctrl(ACT_WRITE_LEN, len);
            cursor = (ph == 2) ? 32'hFFFF_FFF0 : $urandom();
            for (int n = 0; n < PHASE_N; n++)
            begin
                gap = (item_no < 140) ? 35 : (item_no < 280) ? 67 : 0;
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    cursor = cursor + $urandom_range(0, 2 * len + 2);
                else
                    cursor = cursor + $urandom_range(0, len / 3 + 1);
                queue_word(($urandom_range(0, 99) < 55) ? KIND_REGISTER : KIND_SWEEP,
                           $urandom(), PORT_W'($urandom()),
                           (roll >= 92) ? $urandom() : cursor, gap);
                if ($urandom_range(0, 99) < 3)
                    queue_ctrl(ACT_DRAIN, '0);
                item_no++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (requests.size() != 0 || expected_results.size() != 0 || busy)
            @(negedge clk);
        repeat (TAIL) @(negedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hdl/stwe_pkg.sv
hdl/stwe_slot_ram.sv
hdl/stwe_age_cmp.sv
hdl/subscription_table_with_expiry.sv
bench/subscription_table_with_expiry_test.sv
